// File: hdl/avrm_pkg.sv
package avrm_pkg;

  localparam int DW        = 16;
  localparam int FB        = 14;
  localparam int THR_W     = 15;
  localparam int NLANE     = 6;
  localparam int QBITS     = 18;
  localparam int IN_W      = 6 * DW;
  localparam int OUT_W     = 9 * DW;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
  localparam logic signed [DW-1:0] ONE_Q   = DW'(1 << FB);
  localparam logic signed [DW-1:0] NEG_ONE = -ONE_Q;

  typedef enum logic [2:0] {
    LN_SQ_YZ = 3'd0,
    LN_SQ_XZ = 3'd1,
    LN_SQ_XY = 3'd2,
    LN_P_XY  = 3'd3,
    LN_P_XZ  = 3'd4,
    LN_P_YZ  = 3'd5
  } lane_id_t;

  typedef struct packed {
    logic [16:0]      rem;
    logic [31:0]      nm;
    logic [QBITS-1:0] q;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef lane_t [NLANE-1:0] lanes_t;

  typedef struct packed {
    logic signed [DW-1:0] cx;
    logic signed [DW-1:0] cy;
    logic signed [DW-1:0] cz;
    logic [15:0]          dm;
    logic                 dneg;
    logic                 opp;
  } side_t;

endpackage

// File: hdl/align_vectors_rotation_matrix_top.sv
// Requests flow through product, cross/dot, numerator, divider and output stages.
// Throughput: one request per cycle unless out_tready stalls; the 18-step restoring
// divider is fully pipelined, one quotient bit per stage, six lanes in parallel.
// A stalled output freezes the whole pipeline; in_tready follows that stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets the threshold to 1.
module align_vectors_rotation_matrix_top
  import avrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [OUT_W-1:0] out_tdata,
  // opposite_flag
  output logic             out_tuser
);

  logic             en;
  logic [THR_W-1:0] thr_r;

  logic             v1_r, v2_r, v3_r, vo_r;
  logic [QBITS-1:0] vd_r;

  logic signed [17:0] p_r [9];
  side_t  sd2_r, sd3_r;
  lanes_t ln3_r;
  side_t  sdd_r [QBITS];
  lanes_t lnd_r [QBITS];

  logic [OUT_W-1:0] mat_r;
  logic             opp_r;

  assign en         = !vo_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vo_r;
  assign out_tdata  = mat_r;
  assign out_tuser  = opp_r;

  function automatic logic signed [DW-1:0] sat16(input logic signed [20:0] x);
    if (x > 21'sd32767)       return 16'sh7fff;
    else if (x < -21'sd32768) return 16'sh8000;
    else                      return x[DW-1:0];
  endfunction

  function automatic logic signed [17:0] rnd(input logic signed [31:0] p);
    logic signed [32:0] t;
    t = 33'(p) + 33'sd8192;
    return t[31:14];
  endfunction

  function automatic logic [15:0] absv(input logic signed [DW-1:0] x);
    return x[DW-1] ? 16'(-x) : 16'(x);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vd_r <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vd_r <= {vd_r[QBITS-2:0], v3_r};
      vo_r <= vd_r[QBITS-1];
    end
  end

  // stage 1: rounded component products
  logic signed [DW-1:0] a0, a1, a2, b0, b1, b2;
  assign a0 = in_tdata[15:0];
  assign a1 = in_tdata[31:16];
  assign a2 = in_tdata[47:32];
  assign b0 = in_tdata[63:48];
  assign b1 = in_tdata[79:64];
  assign b2 = in_tdata[95:80];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= rnd(32'(a1) * 32'(b2));
      p_r[1] <= rnd(32'(a2) * 32'(b1));
      p_r[2] <= rnd(32'(a2) * 32'(b0));
      p_r[3] <= rnd(32'(a0) * 32'(b2));
      p_r[4] <= rnd(32'(a0) * 32'(b1));
      p_r[5] <= rnd(32'(a1) * 32'(b0));
      p_r[6] <= rnd(32'(a0) * 32'(b0));
      p_r[7] <= rnd(32'(a1) * 32'(b1));
      p_r[8] <= rnd(32'(a2) * 32'(b2));
    end
  end

  // stage 2: cross, dot, denominator
  side_t sd2_nxt;
  logic signed [20:0] dsum;
  logic signed [17:0] den;
  always_comb begin
    sd2_nxt    = '0;
    sd2_nxt.cx = sat16(21'(p_r[0]) - 21'(p_r[1]));
    sd2_nxt.cy = sat16(21'(p_r[2]) - 21'(p_r[3]));
    sd2_nxt.cz = sat16(21'(p_r[4]) - 21'(p_r[5]));
    dsum       = 21'(p_r[6]) + 21'(p_r[7]) + 21'(p_r[8]);
    den        = 18'(ONE_Q) + 18'(sat16(dsum));
    sd2_nxt.dneg = den[17];
    sd2_nxt.dm   = den[17] ? 16'(-den) : den[15:0];
    sd2_nxt.opp  = sd2_nxt.dm <= {1'b0, thr_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r <= sd2_nxt;
    end
  end

  // stage 3: numerator magnitudes and signs
  lanes_t ln3_nxt;
  logic [15:0] mx, my, mz;
  logic sx, sy, sz;
  always_comb begin
    mx = absv(sd2_r.cx);
    my = absv(sd2_r.cy);
    mz = absv(sd2_r.cz);
    sx = sd2_r.cx[DW-1];
    sy = sd2_r.cy[DW-1];
    sz = sd2_r.cz[DW-1];
    ln3_nxt = '0;
    ln3_nxt[LN_SQ_YZ].nm  = 32'(my) * 32'(my) + 32'(mz) * 32'(mz);
    ln3_nxt[LN_SQ_XZ].nm  = 32'(mx) * 32'(mx) + 32'(mz) * 32'(mz);
    ln3_nxt[LN_SQ_XY].nm  = 32'(mx) * 32'(mx) + 32'(my) * 32'(my);
    ln3_nxt[LN_P_XY].nm   = 32'(mx) * 32'(my);
    ln3_nxt[LN_P_XZ].nm   = 32'(mx) * 32'(mz);
    ln3_nxt[LN_P_YZ].nm   = 32'(my) * 32'(mz);
    ln3_nxt[LN_SQ_YZ].neg = !sd2_r.dneg;
    ln3_nxt[LN_SQ_XZ].neg = !sd2_r.dneg;
    ln3_nxt[LN_SQ_XY].neg = !sd2_r.dneg;
    ln3_nxt[LN_P_XY].neg  = sx ^ sy ^ sd2_r.dneg;
    ln3_nxt[LN_P_XZ].neg  = sx ^ sz ^ sd2_r.dneg;
    ln3_nxt[LN_P_YZ].neg  = sy ^ sz ^ sd2_r.dneg;
    for (int i = 0; i < NLANE; i++) begin
      ln3_nxt[i].rem = {3'b0, ln3_nxt[i].nm[31:QBITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r <= sd2_r;
      ln3_r <= ln3_nxt;
    end
  end

  // divider: one quotient bit per stage
  function automatic lane_t div_step(input lane_t l, input logic [15:0] dm,
                                     input logic [4:0] idx, input logic first);
    lane_t o;
    logic [16:0] trial;
    o = l;
    if (first) o.ovf = l.rem >= {1'b0, dm};
    trial = {l.rem[15:0], l.nm[idx]};
    if (trial >= {1'b0, dm}) begin
      o.rem    = trial - {1'b0, dm};
      o.q[idx] = 1'b1;
    end else begin
      o.rem = trial;
    end
    return o;
  endfunction

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    side_t  sd_in;
    lanes_t ln_in, ln_nxt;
    if (k == 0) begin : g_first
      assign sd_in = sd3_r;
      assign ln_in = ln3_r;
    end else begin : g_rest
      assign sd_in = sdd_r[k-1];
      assign ln_in = lnd_r[k-1];
    end
    always_comb begin
      for (int i = 0; i < NLANE; i++) begin
        ln_nxt[i] = div_step(ln_in[i], sd_in.dm, 5'(QBITS - 1 - k), k == 0);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sdd_r[k] <= sd_in;
        lnd_r[k] <= ln_nxt;
      end
    end
  end

  // output stage: round, add base, saturate, or minus identity when opposite
  side_t  sf;
  lanes_t lf;
  logic signed [20:0] tm [NLANE];
  logic [OUT_W-1:0] mat_nxt;
  logic [QBITS:0] qr;
  assign sf = sdd_r[QBITS-1];
  assign lf = lnd_r[QBITS-1];

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      qr = {1'b0, lf[i].q} + ((lf[i].rem >= ({1'b0, sf.dm} - lf[i].rem)) ? 19'd1 : 19'd0);
      if (lf[i].ovf) qr = 19'(1 << QBITS);
      tm[i] = lf[i].neg ? -21'(qr) : 21'(qr);
    end
    if (sf.opp) begin
      mat_nxt = {NEG_ONE, 48'h0, NEG_ONE, 48'h0, NEG_ONE};
    end else begin
      mat_nxt = {sat16(21'(ONE_Q) + tm[LN_SQ_XY]),
                 sat16(21'(sf.cx) + tm[LN_P_YZ]),
                 sat16(-21'(sf.cy) + tm[LN_P_XZ]),
                 sat16(-21'(sf.cx) + tm[LN_P_YZ]),
                 sat16(21'(ONE_Q) + tm[LN_SQ_XZ]),
                 sat16(21'(sf.cz) + tm[LN_P_XY]),
                 sat16(21'(sf.cy) + tm[LN_P_XZ]),
                 sat16(-21'(sf.cz) + tm[LN_P_XY]),
                 sat16(21'(ONE_Q) + tm[LN_SQ_YZ])};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat_r <= mat_nxt;
      opp_r <= sf.opp;
    end
  end

endmodule

// File: hdl/avrm_checker.sv
module avrm_sva
  import avrm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output changed");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken during output stall");

  a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata == {NEG_ONE, 48'h0, NEG_ONE, 48'h0, NEG_ONE})
    else $error("opposite result is not minus identity");

endmodule

bind align_vectors_rotation_matrix_top avrm_sva u_avrm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/avrm_checker.sv
module avrm_checker
  import avrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tuser,
  output int               fail_count,
  output int               pending,
  output int               opposite_seen,
  output int               results_seen
);

  typedef struct {
    logic [DW-1:0] m [9];
    logic          opp;
  } rotation_t;

  rotation_t matrix_q[$];
  logic [THR_W-1:0] threshold;

  function automatic longint sat16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint round_frac(longint p);
    return (p + (longint'(1) << (FB - 1))) >>> FB;
  endfunction

  function automatic longint quot_round(bit nneg, longint nm, longint den);
    longint dm, q, r, cap;
    bit dneg;
    dneg = den < 0;
    dm = dneg ? -den : den;
    q = nm / dm;
    r = nm % dm;
    cap = longint'(1) << 62;
    if (r >= dm - r) q++;
    if (q > cap) q = cap;
    return (nneg != dneg) ? -q : q;
  endfunction

  function automatic longint cross_term(longint a, longint b, longint den);
    longint ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    return quot_round((a < 0) != (b < 0), ma * mb, den);
  endfunction

  function automatic longint square_term(longint a, longint b, longint den);
    return quot_round(1'b1, a * a + b * b, den);
  endfunction

  function automatic rotation_t align_rotation(logic [IN_W-1:0] v, logic [THR_W-1:0] thr);
    rotation_t r;
    longint a0, a1, a2, b0, b1, b2, cx, cy, cz, d, den, one;
    longint e [9];
    a0 = longint'($signed(v[0*DW +: DW]));
    a1 = longint'($signed(v[1*DW +: DW]));
    a2 = longint'($signed(v[2*DW +: DW]));
    b0 = longint'($signed(v[3*DW +: DW]));
    b1 = longint'($signed(v[4*DW +: DW]));
    b2 = longint'($signed(v[5*DW +: DW]));
    one = longint'(1) << FB;
    cx = sat16(round_frac(a1 * b2) - round_frac(a2 * b1));
    cy = sat16(round_frac(a2 * b0) - round_frac(a0 * b2));
    cz = sat16(round_frac(a0 * b1) - round_frac(a1 * b0));
    d = sat16(round_frac(a0 * b0) + round_frac(a1 * b1) + round_frac(a2 * b2));
    den = one + d;
    if ((den < 0 ? -den : den) <= longint'(thr)) begin
      foreach (e[i]) e[i] = 0;
      e[0] = -one; e[4] = -one; e[8] = -one;
      r.opp = 1'b1;
    end else begin
      e[0] = one + square_term(cy, cz, den);
      e[1] = -cz + cross_term(cx, cy, den);
      e[2] = cy + cross_term(cx, cz, den);
      e[3] = cz + cross_term(cx, cy, den);
      e[4] = one + square_term(cx, cz, den);
      e[5] = -cx + cross_term(cy, cz, den);
      e[6] = -cy + cross_term(cx, cz, den);
      e[7] = cx + cross_term(cy, cz, den);
      e[8] = one + square_term(cx, cy, den);
      r.opp = 1'b0;
    end
    foreach (e[i]) r.m[i] = DW'(sat16(e[i]));
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    opposite_seen = 0;
    results_seen = 0;
    threshold = THR_RESET;
  end

  always @(posedge clk) begin
    rotation_t want;
    if (!rst_n) begin
      threshold <= THR_RESET;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (in_tvalid && in_tready) matrix_q.push_back(align_rotation(in_tdata, threshold));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser) opposite_seen++;
        if (matrix_q.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          fail_count++;
        end else begin
          want = matrix_q.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (out_tdata[i*DW +: DW] !== want.m[i]) begin
              $error("m%0d%0d expected %h actual %h", i / 3, i % 3, want.m[i],
                     out_tdata[i*DW +: DW]);
              fail_count++;
            end
          end
          if (out_tuser !== want.opp) begin
            $error("opposite_flag expected %b actual %b", want.opp, out_tuser);
            fail_count++;
          end
        end
      end
    end
    pending = matrix_q.size();
  end

endmodule

// File: tb/sv/tb_align_vectors_rotation_matrix_top.sv
module tb_align_vectors_rotation_matrix_top;
  import avrm_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  int               fail_count, pending, opposite_seen, results_seen;
  int               requests_sent = 0;
  bit               long_stall = 1'b0;

  localparam int LATENCY = 22;

  always #6 clk = ~clk;

  align_vectors_rotation_matrix_top dut (.*);

  avrm_checker u_checker (.*);

  function automatic logic [DW-1:0] pick_component();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'hC000;
      4: return 16'h0000;
      5, 6: return DW'($urandom_range(0, 32768)) - 16'h4000;
      default: return DW'($urandom());
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_pair();
    logic [IN_W-1:0] v;
    logic [DW-1:0] c;
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      c = pick_component();
      v[i*DW +: DW] = c;
      // build opposite, near opposite or equal pairs often
      if (k < 3) v[(i+3)*DW +: DW] = -c + DW'($urandom_range(0, 4)) - 16'd2;
      else if (k == 3) v[(i+3)*DW +: DW] = c;
      else v[(i+3)*DW +: DW] = pick_component();
    end
    return v;
  endfunction

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_request(logic [IN_W-1:0] v);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      random_gap();
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic stop_requests();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_request(random_pair());
    stop_requests();
  endtask

  always @(negedge clk) begin
    if (long_stall) out_tready <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_tready <= 1'b0;
    else if ($urandom_range(0, 2) != 0) out_tready <= 1'b1;
  end

  initial begin
    int i;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_request({16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000});
    send_request({16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000});
    send_request({16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000});
    send_request({16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000});
    send_request({6{16'h7FFF}});
    send_request({6{16'h8000}});
    send_request({{3{16'h8000}}, {3{16'h7FFF}}});
    send_request({{3{16'h7FFF}}, {3{16'h8000}}});
    send_request('0);
    send_request({16'h0000, 16'h0000, 16'hC001, 16'h0000, 16'h0000, 16'h4000});
    send_request({16'h0000, 16'h0000, 16'hC002, 16'h0000, 16'h0000, 16'h4000});
    send_request({16'h1000, 16'h2000, 16'h3000, 16'hF000, 16'hE000, 16'hD000});
    send_request({16'h2D41, 16'h2D41, 16'h0000, 16'h0000, 16'h0000, 16'h4000});
    send_request({16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'hC000});
    stop_requests();
    write_threshold(15'h7FFF);
    send_request({16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000});
    send_request({6{16'h7FFF}});
    stop_requests();
    write_threshold(15'd0);
    send_request({16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000});
    send_request({16'h0000, 16'h0000, 16'hC001, 16'h0000, 16'h0000, 16'h4000});
    random_phase(250);
    // hold the receiver while requests keep coming
    fork
      begin
        long_stall = 1'b1;
        repeat (120) @(negedge clk);
        long_stall = 1'b0;
      end
      random_phase(80);
    join
    while (pending != 0) @(negedge clk);
    write_threshold(15'd200);
    random_phase(200);
    write_threshold(15'd5000);
    random_phase(150);
    write_threshold(15'd1);
    for (i = 0; i < 150; i++) begin
      in_tvalid <= 1'b1;
      in_tdata <= random_pair();
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      requests_sent++;
      @(negedge clk);
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("Sent %0d pairs, checked %0d matrices, %0d flagged opposite, threshold 0..32767.",
             requests_sent, results_seen, opposite_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[align_vectors_rotation_matrix_top] OK");
    end else begin
      $display("[align_vectors_rotation_matrix_top] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[align_vectors_rotation_matrix_top] ERROR");
    $finish;
  end

endmodule
